// File: src/wavetable_bilinear_readout_macros.svh
// ----------------------------------------------------------------------------
// wavetable bilinear readout assertion macros
// concurrent assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_BILINEAR_READOUT_MACROS_SVH
`define WAVETABLE_BILINEAR_READOUT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising clock edge, off while reset is high
`define WBR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define WBR_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define WBR_ASSERT(label, prop, msg)

`define WBR_ASSERT_NR(label, prop, msg)

`endif

`endif

// File: src/wbr_pkg.sv
// ----------------------------------------------------------------------------
// wbr_pkg
// table geometry, field widths, command codes and the structs passed from the
// address stage to the table banks and the interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package wbr_pkg;

   // table geometry, both powers of two
   localparam int TABLE_SIZE = 2048;
   localparam int NUM_FRAMES = 8;

   // fixed field widths
   localparam int CMD_W       = 1;
   localparam int FRAME_IDX_W = 3;
   localparam int ENTRY_IDX_W = 11;
   localparam int SAMPLE_W    = 16;
   localparam int PHASE_W     = 32;
   localparam int FPOS_W      = 18;
   localparam int FRAC_W      = 16;

   // derived widths
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int FRM_W      = $clog2(NUM_FRAMES);
   localparam int ROW_W      = IDX_W - 1;
   localparam int ADDR_W     = FRM_W + ROW_W;
   localparam int BANK_DEPTH = TABLE_SIZE * NUM_FRAMES / 2;
   localparam int UPOS_W     = FRAC_W + 1;
   localparam int FP_W       = FRAC_W + FRM_W;
   localparam int PROD_W     = SAMPLE_W + FRAC_W + 1;
   localparam int UNITY      = 1 << FRAC_W;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [FRAC_W-1:0]          frac_type;
   typedef logic [ADDR_W-1:0]          addr_type;

   typedef struct packed {
      logic       en;
      logic       bank;
      addr_type   addr;
      sample_type data;
   } wr_req_type;

   typedef struct packed {
      logic     valid;
      addr_type even_addr0;
      addr_type even_addr1;
      addr_type odd_addr0;
      addr_type odd_addr1;
      logic     swap;
      frac_type tfrac;
      frac_type ffrac;
   } rd_req_type;

endpackage

`default_nettype wire

// File: src/wbr_bank.sv
// ----------------------------------------------------------------------------
// wbr_bank
// one table bank: synchronous ram, one write port and two read ports with
// registered read data, all held while the pipeline is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module wbr_bank (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic               wr_en,
   input  wire wbr_pkg::addr_type   wr_addr,
   input  wire wbr_pkg::sample_type wr_data,
   input  wire wbr_pkg::addr_type   rd_addr0,
   input  wire wbr_pkg::addr_type   rd_addr1,
   output wbr_pkg::sample_type      rd_data0,
   output wbr_pkg::sample_type      rd_data1
);
   import wbr_pkg::*;

   sample_type mem [BANK_DEPTH];
   sample_type rd_data0_ff;
   sample_type rd_data1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         rd_data0_ff <= mem[rd_addr0];
         rd_data1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

// File: src/wbr_front.sv
// ----------------------------------------------------------------------------
// wbr_front
// request stage: decodes the transfer into a bank write or into four bank
// read addresses with table and frame fractions
// ----------------------------------------------------------------------------
`default_nettype none

module wbr_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            req_take,
   input  wire logic [wbr_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [wbr_pkg::FRAME_IDX_W-1:0] req_frame_index,
   input  wire logic [wbr_pkg::ENTRY_IDX_W-1:0] req_entry_index,
   input  wire logic signed [wbr_pkg::SAMPLE_W-1:0] req_entry_value,
   input  wire logic [wbr_pkg::PHASE_W-1:0]     req_phase,
   input  wire logic signed [wbr_pkg::FPOS_W-1:0] req_frame_pos,
   output wbr_pkg::wr_req_type                  wr,
   output wbr_pkg::rd_req_type                  rd
);
   import wbr_pkg::*;

   wr_req_type       wr_ff, wr_in;
   rd_req_type       rd_ff, rd_in;
   logic [IDX_W-1:0] entry;
   logic             in_range;
   logic [UPOS_W-1:0] fpos;
   logic [FP_W-1:0]  fp;
   logic [FRM_W-1:0] f0, f1;
   logic [IDX_W-1:0] i0, i1;
   logic [ROW_W-1:0] even_row, odd_row;

   // write decode
   always_comb begin
      entry    = IDX_W'(req_entry_index);
      in_range = (int'(req_frame_index) < NUM_FRAMES) &&
                 (int'(req_entry_index) < TABLE_SIZE);
      wr_in.en   = req_take && (req_cmd == CMD_WRITE) && in_range;
      wr_in.bank = entry[0];
      wr_in.addr = {FRM_W'(req_frame_index), entry[IDX_W-1:1]};
      wr_in.data = req_entry_value;
   end

   // sample decode
   always_comb begin
      if (req_frame_pos[FPOS_W-1]) begin
         fpos = '0;
      end else if (req_frame_pos[UPOS_W-1:0] > UPOS_W'(UNITY)) begin
         fpos = UPOS_W'(UNITY);
      end else begin
         fpos = req_frame_pos[UPOS_W-1:0];
      end
      fp = FP_W'(FP_W'(fpos) * FP_W'(NUM_FRAMES - 1));
      f0 = fp[FRAC_W +: FRM_W];
      f1 = (f0 == FRM_W'(NUM_FRAMES - 1)) ? f0 : f0 + 1'b1;

      i0       = req_phase[PHASE_W-1 -: IDX_W];
      i1       = i0 + 1'b1;
      even_row = i0[0] ? i1[IDX_W-1:1] : i0[IDX_W-1:1];
      odd_row  = i0[IDX_W-1:1];

      rd_in.valid      = req_take && (req_cmd == CMD_SAMPLE);
      rd_in.even_addr0 = {f0, even_row};
      rd_in.even_addr1 = {f1, even_row};
      rd_in.odd_addr0  = {f0, odd_row};
      rd_in.odd_addr1  = {f1, odd_row};
      rd_in.swap       = i0[0];
      rd_in.tfrac      = req_phase[PHASE_W-1-IDX_W -: FRAC_W];
      rd_in.ffrac      = fp[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff.en    <= 1'b0;
         rd_ff.valid <= 1'b0;
      end else if (adv) begin
         wr_ff.en    <= wr_in.en;
         rd_ff.valid <= rd_in.valid;
      end
      if (adv) begin
         wr_ff.bank       <= wr_in.bank;
         wr_ff.addr       <= wr_in.addr;
         wr_ff.data       <= wr_in.data;
         rd_ff.even_addr0 <= rd_in.even_addr0;
         rd_ff.even_addr1 <= rd_in.even_addr1;
         rd_ff.odd_addr0  <= rd_in.odd_addr0;
         rd_ff.odd_addr1  <= rd_in.odd_addr1;
         rd_ff.swap       <= rd_in.swap;
         rd_ff.tfrac      <= rd_in.tfrac;
         rd_ff.ffrac      <= rd_in.ffrac;
      end
   end

   assign wr = wr_ff;
   assign rd = rd_ff;

endmodule

`default_nettype wire

// File: src/wbr_lerp.sv
// ----------------------------------------------------------------------------
// wbr_lerp
// interpolation pipeline: orders the bank data, interpolates along the table
// in both frames, then between the frames, and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module wbr_lerp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire wbr_pkg::rd_req_type  rd,
   input  wire wbr_pkg::sample_type  even_data0,
   input  wire wbr_pkg::sample_type  even_data1,
   input  wire wbr_pkg::sample_type  odd_data0,
   input  wire wbr_pkg::sample_type  odd_data1,
   output logic                     out_valid,
   output wbr_pkg::sample_type       out_value
);
   import wbr_pkg::*;

   function automatic logic signed [PROD_W-1:0] diff_mul(sample_type a, sample_type b,
                                                         frac_type f);
      logic signed [SAMPLE_W:0]     d;
      logic signed [PROD_W:0]       full;
      d    = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
      full = (PROD_W+1)'(d) * (PROD_W+1)'($signed({1'b0, f}));
      return full[PROD_W-1:0];
   endfunction

   function automatic sample_type add_step(sample_type a, logic signed [PROD_W-1:0] p);
      logic signed [SAMPLE_W:0] s;
      s = $signed({a[SAMPLE_W-1], a}) + $signed(p[PROD_W-1:FRAC_W]);
      return s[SAMPLE_W-1:0];
   endfunction

   // b: aligned with bank read data
   logic       b_valid_ff;
   logic       b_swap_ff;
   frac_type   b_tfrac_ff, b_ffrac_ff;
   sample_type a0, n0, a1, n1;

   // c: products along the table
   logic                     c_valid_ff;
   sample_type               c_a0_ff, c_a1_ff;
   logic signed [PROD_W-1:0] c_p0_ff, c_p1_ff;
   frac_type                 c_ffrac_ff;

   // d: per-frame values
   logic       d_valid_ff;
   sample_type d_v0_ff, d_v1_ff;
   frac_type   d_ffrac_ff;

   // e: product between frames
   logic                     e_valid_ff;
   sample_type               e_v0_ff;
   logic signed [PROD_W-1:0] e_p_ff;

   // f: result register
   logic       rsp_valid_ff;
   sample_type rsp_value_ff;

   always_comb begin
      a0 = b_swap_ff ? odd_data0  : even_data0;
      n0 = b_swap_ff ? even_data0 : odd_data0;
      a1 = b_swap_ff ? odd_data1  : even_data1;
      n1 = b_swap_ff ? even_data1 : odd_data1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff   <= rd.valid;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_swap_ff    <= rd.swap;
         b_tfrac_ff   <= rd.tfrac;
         b_ffrac_ff   <= rd.ffrac;

         c_a0_ff      <= a0;
         c_a1_ff      <= a1;
         c_p0_ff      <= diff_mul(a0, n0, b_tfrac_ff);
         c_p1_ff      <= diff_mul(a1, n1, b_tfrac_ff);
         c_ffrac_ff   <= b_ffrac_ff;

         d_v0_ff      <= add_step(c_a0_ff, c_p0_ff);
         d_v1_ff      <= add_step(c_a1_ff, c_p1_ff);
         d_ffrac_ff   <= c_ffrac_ff;

         e_v0_ff      <= d_v0_ff;
         e_p_ff       <= diff_mul(d_v0_ff, d_v1_ff, d_ffrac_ff);

         rsp_value_ff <= add_step(e_v0_ff, e_p_ff);
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_value = rsp_value_ff;

endmodule

`default_nettype wire

// File: src/wavetable_bilinear_readout.sv
// ----------------------------------------------------------------------------
// wavetable_bilinear_readout
// one request transfer per cycle while req_stall is low; a sample result passes
// through every stage below in order and then loads the output register
// stages: request decode, bank read, table products, frame values, frame
// product, result register; the two-port table banks set the one-per-cycle pace
// a stalled result freezes every stage; synchronous reset empties the pipeline,
// table contents are undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_bilinear_readout (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [wbr_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [wbr_pkg::FRAME_IDX_W-1:0]     req_frame_index,
   input  wire logic [wbr_pkg::ENTRY_IDX_W-1:0]     req_entry_index,
   input  wire logic signed [wbr_pkg::SAMPLE_W-1:0] req_entry_value,
   input  wire logic [wbr_pkg::PHASE_W-1:0]         req_phase,
   input  wire logic signed [wbr_pkg::FPOS_W-1:0]   req_frame_pos,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [wbr_pkg::SAMPLE_W-1:0]      rsp_sample_value
);
   import wbr_pkg::*;

   `include "wavetable_bilinear_readout_macros.svh"

   logic       adv;
   logic       req_take;
   wr_req_type front_wr;
   rd_req_type front_rd;
   sample_type even_data0, even_data1, odd_data0, odd_data1;
   sample_type out_value;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign req_take  = req_valid && adv;

   wbr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_take        (req_take),
      .req_cmd         (req_cmd),
      .req_frame_index (req_frame_index),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_phase       (req_phase),
      .req_frame_pos   (req_frame_pos),
      .wr              (front_wr),
      .rd              (front_rd)
   );

   // even table positions
   wbr_bank u_bank_even (
      .clock    (clock),
      .en       (adv),
      .wr_en    (front_wr.en && !front_wr.bank),
      .wr_addr  (front_wr.addr),
      .wr_data  (front_wr.data),
      .rd_addr0 (front_rd.even_addr0),
      .rd_addr1 (front_rd.even_addr1),
      .rd_data0 (even_data0),
      .rd_data1 (even_data1)
   );

   // odd table positions
   wbr_bank u_bank_odd (
      .clock    (clock),
      .en       (adv),
      .wr_en    (front_wr.en && front_wr.bank),
      .wr_addr  (front_wr.addr),
      .wr_data  (front_wr.data),
      .rd_addr0 (front_rd.odd_addr0),
      .rd_addr1 (front_rd.odd_addr1),
      .rd_data0 (odd_data0),
      .rd_data1 (odd_data1)
   );

   wbr_lerp u_lerp (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .rd         (front_rd),
      .even_data0 (even_data0),
      .even_data1 (even_data1),
      .odd_data0  (odd_data0),
      .odd_data1  (odd_data1),
      .out_valid  (rsp_valid),
      .out_value  (out_value)
   );

   assign rsp_sample_value = out_value;

   `WBR_ASSERT_NR(a_idle_after_reset, $past(reset) |-> !rsp_valid, "result valid after reset")
   `WBR_ASSERT(a_stall_freezes_front, (rsp_valid && rsp_stall) |=> $stable(front_rd.valid) && $stable(front_wr.en), "request stage moved while stalled")
   `WBR_ASSERT(a_one_item_in_front, front_wr.en |-> !front_rd.valid, "write and sample in one stage")
   `WBR_ASSERT(a_stall_needs_result, req_stall |-> rsp_valid, "request stalled with no result waiting")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// wavetable_bilinear_readout testbench
// loads table entries on demand ahead of every sample request so that no read
// touches an unwritten entry, predicts each interpolated sample from a local
// copy of the table, and checks results in order under random idle and stall
// on both channels, with one long result hold-off that backs up the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
   int f0;
   int f1;
   int i0;
   int i1;
   int tfrac;
   int ffrac;
} read_taps_type;

class sample_scoreboard;
   localparam int DEPTH = wbr_pkg::TABLE_SIZE * wbr_pkg::NUM_FRAMES;

   wbr_pkg::sample_type wave_mem [DEPTH];
   wbr_pkg::sample_type expected_samples [$];
   int checked = 0;
   int failures = 0;

   function read_taps_type plan_read(logic [31:0] phase, logic signed [17:0] fpos);
      read_taps_type t;
      logic [63:0] pos;
      int fsat;
      int fp;
      pos = {32'd0, phase} * 64'(wbr_pkg::TABLE_SIZE);
      t.i0 = int'((pos >> 32) % wbr_pkg::TABLE_SIZE);
      t.i1 = (t.i0 + 1) % wbr_pkg::TABLE_SIZE;
      t.tfrac = int'(pos[31:16]);
      if (fpos < 0)
         fsat = 0;
      else if (int'(fpos) > wbr_pkg::UNITY)
         fsat = wbr_pkg::UNITY;
      else
         fsat = int'(fpos);
      fp = fsat * (wbr_pkg::NUM_FRAMES - 1);
      t.f0 = fp >> 16;
      if (t.f0 > wbr_pkg::NUM_FRAMES - 1)
         t.f0 = wbr_pkg::NUM_FRAMES - 1;
      t.f1 = (t.f0 + 1 > wbr_pkg::NUM_FRAMES - 1) ? wbr_pkg::NUM_FRAMES - 1 : t.f0 + 1;
      t.ffrac = fp & 16'hFFFF;
      return t;
   endfunction

   // a + floor((b - a) * f / 2^16)
   function int blend(int a, int b, int f);
      longint prod;
      prod = longint'(b - a) * longint'(f);
      return a + int'(prod >>> 16);
   endfunction

   function int entry_at(int frame, int idx);
      return int'(wave_mem[frame * wbr_pkg::TABLE_SIZE + idx]);
   endfunction

   function wbr_pkg::sample_type interpolate(logic [31:0] phase, logic signed [17:0] fpos);
      read_taps_type t;
      int v0;
      int v1;
      t = plan_read(phase, fpos);
      v0 = blend(entry_at(t.f0, t.i0), entry_at(t.f0, t.i1), t.tfrac);
      v1 = blend(entry_at(t.f1, t.i0), entry_at(t.f1, t.i1), t.tfrac);
      return wbr_pkg::sample_type'(blend(v0, v1, t.ffrac));
   endfunction

   function void note_request(logic cmd, logic [2:0] fi, logic [10:0] ei,
                              logic signed [15:0] val, logic [31:0] phase,
                              logic signed [17:0] fpos);
      if (cmd == wbr_pkg::CMD_WRITE) begin
         if (int'(fi) < wbr_pkg::NUM_FRAMES && int'(ei) < wbr_pkg::TABLE_SIZE)
            wave_mem[int'(fi) * wbr_pkg::TABLE_SIZE + int'(ei)] = val;
      end else begin
         expected_samples.push_back(interpolate(phase, fpos));
      end
   endfunction

   function void check_result(wbr_pkg::sample_type actual);
      wbr_pkg::sample_type want;
      checked++;
      if (expected_samples.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected sample %0d with no request pending", actual);
         return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
         failures++;
         if (failures <= 10)
            $display("sample %0d mismatch: expected %0d got %0d", checked, want, actual);
      end
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction
endclass

module testbench;
   import wbr_pkg::*;

   localparam int ITEM_GOAL   = 1670;
   localparam int HOLD_CYCLES = 400;
   localparam int STUCK_LIMIT = 3000;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_cmd = CMD_WRITE;
   logic [FRAME_IDX_W-1:0]     req_frame_index = '0;
   logic [ENTRY_IDX_W-1:0]     req_entry_index = '0;
   logic signed [SAMPLE_W-1:0] req_entry_value = '0;
   logic [PHASE_W-1:0]         req_phase = '0;
   logic signed [FPOS_W-1:0]   req_frame_pos = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_value;

   sample_scoreboard sb = new();
   bit written [TABLE_SIZE*NUM_FRAMES];
   int items_sent = 0;
   bit quiet = 1'b0;
   int unsigned stuck_cycles = 0;

   wavetable_bilinear_readout uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_frame_index  (req_frame_index),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_phase        (req_phase),
      .req_frame_pos    (req_frame_pos),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [15:0] random_entry();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] random_phase();
      case ($urandom_range(0, 7))
         0: return {11'h7FF, 21'($urandom)};
         1: return {11'($urandom_range(0, 15)), 21'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [17:0] random_frame_pos();
      case ($urandom_range(0, 7))
         0: return {1'b1, 17'($urandom)};
         1: return 18'($urandom_range(65537, 131071));
         2: return ($urandom_range(0, 1) == 1) ? 18'sd0 : 18'sd65536;
         default: return 18'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic send_item(input logic cmd, input logic [2:0] fi, input logic [10:0] ei,
                            input logic signed [15:0] val, input logic [31:0] phase,
                            input logic signed [17:0] fpos);
      while (!quiet && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_frame_index <= fi;
      req_entry_index <= ei;
      req_entry_value <= val;
      req_phase       <= phase;
      req_frame_pos   <= fpos;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.note_request(cmd, fi, ei, val, phase, fpos);
      if (cmd == CMD_WRITE)
         written[int'(fi) * TABLE_SIZE + int'(ei)] = 1'b1;
      items_sent++;
   endtask

   task automatic write_entry(input logic [2:0] fi, input logic [10:0] ei,
                              input logic signed [15:0] val);
      send_item(CMD_WRITE, fi, ei, val, $urandom, 18'($urandom));
   endtask

   // load any of the four taps not yet written, then request the sample
   task automatic sample_at(input logic [31:0] phase, input logic signed [17:0] fpos);
      read_taps_type t;
      int frames [2];
      int idx [2];
      t = sb.plan_read(phase, fpos);
      frames = '{t.f0, t.f1};
      idx = '{t.i0, t.i1};
      foreach (frames[a]) begin
         foreach (idx[b]) begin
            if (!written[frames[a] * TABLE_SIZE + idx[b]])
               write_entry(3'(frames[a]), 11'(idx[b]), random_entry());
         end
      end
      send_item(CMD_SAMPLE, 3'($urandom), 11'($urandom), 16'($urandom), phase, fpos);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // extreme entries, including full-scale steps between neighbors
      write_entry(3'd0, 11'd0, 16'sh7FFF);
      write_entry(3'd0, 11'd1, 16'sh8000);
      write_entry(3'd7, 11'd2047, 16'sh8000);
      write_entry(3'd7, 11'd0, 16'sh7FFF);
      sample_at(32'h0000_0000, 18'sd0);
      sample_at(32'h001F_FFFF, 18'sd0);
      sample_at(32'hFFFF_FFFF, 18'sd65536);
      sample_at(32'h0000_0000, 18'sh20000);
      sample_at(32'hFFFF_FFFF, 18'sh1FFFF);
      sample_at(32'h8000_8000, 18'sd65535);
      sample_at(32'h7FFF_0000, 18'sd32768);

      while (items_sent < ITEM_GOAL) begin
         quiet = (items_sent >= 700 && items_sent < 1000);
         if ($urandom_range(0, 99) < 40)
            write_entry(3'($urandom), 11'($urandom), random_entry());
         else
            sample_at(random_phase(), random_frame_pos());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: check each transfer, random stall, one long hold-off
   initial begin : result_side
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            sb.check_result(rsp_sample_value);
         if (!held && sb.checked >= 200) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (!quiet && $urandom_range(0, 99) < 28);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", stuck_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end
endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/wbr_pkg.sv
src/wbr_bank.sv
src/wbr_front.sv
src/wbr_lerp.sv
src/wavetable_bilinear_readout.sv
dv/testbench.sv
